>>> rtl/fbop_pkg.sv
// ----------------------------------------------------------------------------
// Frame buffer ownership pool package
// Command codes, ownership codes, the no-frame tag and the sequencer states.
// ----------------------------------------------------------------------------
package fbop_pkg;

   localparam int CMD_W   = 3;
   localparam int SLOT_W  = 4;
   localparam int FRAME_W = 31;
   localparam int TAG_W   = 32;
   localparam int OWN_W   = 2;

   typedef logic [CMD_W-1:0] cmd_type;
   typedef logic [OWN_W-1:0] owner_type;
   typedef logic [TAG_W-1:0] tag_type;

   localparam cmd_type CMD_CLAIM_FREE   = 3'd0;
   localparam cmd_type CMD_MARK_FILLED  = 3'd1;
   localparam cmd_type CMD_CLAIM_FILLED = 3'd2;
   localparam cmd_type CMD_MARK_READY   = 3'd3;
   localparam cmd_type CMD_CLAIM_READY  = 3'd4;
   localparam cmd_type CMD_MARK_FREE    = 3'd5;

   localparam owner_type OWN_FREE   = 2'd0;
   localparam owner_type OWN_INUSE  = 2'd1;
   localparam owner_type OWN_FILLED = 2'd2;
   localparam owner_type OWN_READY  = 2'd3;

   // All ones marks a slot with no frame; as a signed value it is -1.
   localparam tag_type NO_FRAME = 32'hFFFF_FFFF;
   localparam tag_type SIGN_FLIP = 32'h8000_0000;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_FINISH,
      FSM_RESP
   } fsm_state_type;

endpackage

>>> rtl/frame_buffer_ownership_pool_unit.sv
// ----------------------------------------------------------------------------
// Frame buffer ownership pool
// Ownership state table for a pool of frame buffers, kept in on-chip memory.
// ----------------------------------------------------------------------------
// The block takes one command transaction at a time and returns exactly one
// response transaction for it. Mark commands (mark filled, mark ready, mark
// free) write the addressed slot in the cycle the command is accepted, and the
// response is offered on the next cycle. Claim commands (claim free, claim
// filled, claim ready) walk the slot table through the single read port of the
// table memories, one slot per cycle, then write the chosen slot, if one is
// found, back as in use. The memory read port, visited once per slot, sets the
// length of a claim. A new command is accepted once the previous response has
// been taken. Reset leaves every slot free with no frame; no clearing pass is
// needed, since per-slot valid bits make an unwritten entry read as its reset
// value.
// ----------------------------------------------------------------------------
module frame_buffer_ownership_pool_unit #(
   parameter int SLOT_COUNT = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  fbop_pkg::cmd_type     req_cmd,
   input  logic [3:0]            req_slot_index,
   input  logic [30:0]           req_frame_number,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_ok,
   output logic [3:0]            rsp_granted_slot
);

   import fbop_pkg::*;

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);

   // Sequencer state.
   fsm_state_type state_ff, state_in;

   // Table memories: ownership code and frame tag, one entry per slot.
   owner_type owner_mem [SLOT_COUNT];
   tag_type   tag_mem   [SLOT_COUNT];

   // Valid bits: an entry that was never written reads as its reset value.
   logic [SLOT_COUNT-1:0] own_vld_ff;
   logic [SLOT_COUNT-1:0] tag_vld_ff;

   // Registered read port.
   owner_type rd_owner_ff;
   tag_type   rd_tag_ff;
   logic      rd_own_vld_ff;
   logic      rd_tag_vld_ff;

   // Scan bookkeeping.
   logic [CNT_W-1:0] issue_cnt_ff;
   logic             chk_vld_ff;
   logic [IDX_W-1:0] chk_idx_ff;
   cmd_type          cmd_ff;
   logic             found_ff;
   logic [IDX_W-1:0] best_idx_ff;
   tag_type          best_key_ff;

   // Response register.
   logic       rsp_valid_ff;
   logic       rsp_ok_ff;
   logic [3:0] rsp_slot_ff;

   // Control signals from the output decoder.
   logic             accept;
   logic             in_range;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             own_we;
   logic [IDX_W-1:0] own_wa;
   owner_type        own_wd;
   logic             tag_we;
   tag_type          tag_wd;
   logic             rsp_load;
   logic             rsp_ok_in;
   logic [3:0]       rsp_slot_in;

   // Scan datapath.
   owner_type  eff_owner;
   tag_type    eff_tag;
   tag_type    cur_key;
   owner_type  want_owner;
   logic       is_ready_claim;
   logic       take;
   logic       scan_done;

   assign accept   = req_valid && !req_stall;
   assign in_range = {1'b0, req_slot_index} < 5'(SLOT_COUNT);
   assign rd_addr  = issue_cnt_ff[IDX_W-1:0];

   // ---------------------------------------------------------------------
   // Scan evaluation: compare the slot just read against the best so far.
   // ---------------------------------------------------------------------
   always_comb begin
      eff_owner = rd_own_vld_ff ? rd_owner_ff : OWN_FREE;
      eff_tag   = rd_tag_vld_ff ? rd_tag_ff : NO_FRAME;
      // Flipping the sign bit lets an unsigned compare order signed tags.
      cur_key   = eff_tag ^ SIGN_FLIP;
      is_ready_claim = (cmd_ff == CMD_CLAIM_READY);
      case (cmd_ff)
         CMD_CLAIM_FREE:   want_owner = OWN_FREE;
         CMD_CLAIM_FILLED: want_owner = OWN_FILLED;
         default:          want_owner = OWN_READY;
      endcase
      // First match wins for the free and filled claims; the ready claim keeps
      // the smallest tag and, on a tie, the lower slot seen earlier.
      take = chk_vld_ff && (eff_owner == want_owner) &&
             (!found_ff || (is_ready_claim && (cur_key < best_key_ff)));
      scan_done = chk_vld_ff && (chk_idx_ff == IDX_W'(SLOT_COUNT - 1));
   end

   // ---------------------------------------------------------------------
   // Next-state logic.
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (req_valid) begin
               if (req_cmd == CMD_CLAIM_FREE || req_cmd == CMD_CLAIM_FILLED ||
                   req_cmd == CMD_CLAIM_READY) begin
                  state_in = FSM_SCAN;
               end else begin
                  state_in = FSM_RESP;
               end
            end
         end
         FSM_SCAN: begin
            if (scan_done) begin
               state_in = FSM_FINISH;
            end
         end
         FSM_FINISH: begin
            state_in = FSM_RESP;
         end
         FSM_RESP: begin
            if (!rsp_stall) begin
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Output decoder: handshake, memory writes and response loading.
   // ---------------------------------------------------------------------
   always_comb begin
      req_stall   = 1'b1;
      rd_en       = 1'b0;
      own_we      = 1'b0;
      own_wa      = req_slot_index[IDX_W-1:0];
      own_wd      = OWN_FREE;
      tag_we      = 1'b0;
      tag_wd      = NO_FRAME;
      rsp_load    = 1'b0;
      rsp_ok_in   = 1'b0;
      rsp_slot_in = 4'd0;
      unique case (state_ff)
         FSM_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               // Marks update the table right away; claims wait for the scan.
               unique case (req_cmd) inside
                  CMD_MARK_FILLED: begin
                     own_we    = in_range;
                     own_wd    = OWN_FILLED;
                     tag_we    = in_range;
                     tag_wd    = {1'b0, req_frame_number};
                     rsp_load  = 1'b1;
                     rsp_ok_in = in_range;
                  end
                  CMD_MARK_READY: begin
                     own_we    = in_range;
                     own_wd    = OWN_READY;
                     rsp_load  = 1'b1;
                     rsp_ok_in = in_range;
                  end
                  CMD_MARK_FREE: begin
                     own_we    = in_range;
                     own_wd    = OWN_FREE;
                     tag_we    = in_range;
                     tag_wd    = NO_FRAME;
                     rsp_load  = 1'b1;
                     rsp_ok_in = in_range;
                  end
                  CMD_CLAIM_FREE, CMD_CLAIM_FILLED, CMD_CLAIM_READY: begin
                     rsp_load = 1'b0;
                  end
                  default: begin
                     // Unknown commands change nothing and report failure.
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         FSM_SCAN: begin
            rd_en = (issue_cnt_ff < CNT_W'(SLOT_COUNT));
         end
         FSM_FINISH: begin
            own_we      = found_ff;
            own_wa      = best_idx_ff;
            own_wd      = OWN_INUSE;
            rsp_load    = 1'b1;
            rsp_ok_in   = found_ff;
            rsp_slot_in = found_ff ? 4'(best_idx_ff) : 4'd0;
         end
         FSM_RESP: begin
            req_stall = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Table memories with one registered read port.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (own_we) begin
         owner_mem[own_wa] <= own_wd;
      end
      if (tag_we) begin
         tag_mem[own_wa] <= tag_wd;
      end
      if (rd_en) begin
         rd_owner_ff   <= owner_mem[rd_addr];
         rd_tag_ff     <= tag_mem[rd_addr];
         rd_own_vld_ff <= own_vld_ff[rd_addr];
         rd_tag_vld_ff <= tag_vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_vld_ff <= '0;
         tag_vld_ff <= '0;
      end else begin
         if (own_we) begin
            own_vld_ff[own_wa] <= 1'b1;
         end
         if (tag_we) begin
            tag_vld_ff[own_wa] <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer and scan control registers.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         issue_cnt_ff <= '0;
         chk_vld_ff   <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         chk_vld_ff <= rd_en;
         if (accept) begin
            issue_cnt_ff <= '0;
            found_ff     <= 1'b0;
         end else begin
            if (rd_en) begin
               issue_cnt_ff <= issue_cnt_ff + CNT_W'(1);
            end
            if (take) begin
               found_ff <= 1'b1;
            end
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_cmd;
      end
      if (rd_en) begin
         chk_idx_ff <= rd_addr;
      end
      if (take) begin
         best_idx_ff <= chk_idx_ff;
         best_key_ff <= cur_key;
      end
      if (rsp_load) begin
         rsp_ok_ff   <= rsp_ok_in;
         rsp_slot_ff <= rsp_slot_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_granted_slot = rsp_slot_ff;

endmodule
